>>> rtl/rtd_pkg.sv
// shared constants, types and tables of the 2d rigid transform block
package rtd_pkg;

	localparam int CoordWidth  = 32;
	localparam int CordicSteps = 16;
	localparam int AngleWidth  = 18;
	localparam int TrigWidth   = 18;
	localparam int TrigFrac    = 16;
	localparam int CordicFrac  = 30;
	localparam int CordicWidth = 34;
	localparam int ZWidth      = 20;
	localparam int StepWidth   = $clog2(CordicSteps + 1);
	localparam int CordicGain  = 652032875;
	localparam int TrigOne     = 65536;
	localparam int HalfTurn    = 131072;
	localparam int QuarterTurn = 65536;

	localparam int ProdWidth = CoordWidth + TrigWidth;
	localparam int SumWidth  = ProdWidth + 1;
	localparam int RndWidth  = SumWidth - TrigFrac;
	localparam int OffWidth  = RndWidth + 1;

	localparam int AddrWidth = 4;
	localparam int DataWidth = 32;

	typedef enum logic [1:0] {
		RegAngle     = 2'd0,
		RegOffsetX   = 2'd1,
		RegOffsetY   = 2'd2,
		RegClockwise = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic                         start;
		logic signed [AngleWidth-1:0] angle;
	} trig_req_t;

	typedef struct packed {
		logic                         busy;
		logic signed [TrigWidth-1:0]  cosine;
		logic signed [TrigWidth-1:0]  sine;
	} trig_t;

	typedef struct packed {
		logic signed [CoordWidth-1:0] offset_x;
		logic signed [CoordWidth-1:0] offset_y;
		logic                         clockwise;
	} xform_cfg_t;

	// atan(2^-i) in units of pi/131072
	function automatic logic [15:0] atan_units(input logic [4:0] i);
		logic [15:0] r;
		case (i)
			5'd0:  r = 16'd32768;
			5'd1:  r = 16'd19344;
			5'd2:  r = 16'd10221;
			5'd3:  r = 16'd5188;
			5'd4:  r = 16'd2604;
			5'd5:  r = 16'd1303;
			5'd6:  r = 16'd652;
			5'd7:  r = 16'd326;
			5'd8:  r = 16'd163;
			5'd9:  r = 16'd81;
			5'd10: r = 16'd41;
			5'd11: r = 16'd20;
			5'd12: r = 16'd10;
			5'd13: r = 16'd5;
			5'd14: r = 16'd3;
			5'd15: r = 16'd1;
			5'd16: r = 16'd1;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/rtd_if.sv
// stream channels for source points and transformed points
interface rtd_point_if
	import rtd_pkg::*;
();
	logic                         valid;
	logic                         ready;
	logic signed [CoordWidth-1:0] point_x;
	logic signed [CoordWidth-1:0] point_y;

	modport source (output valid, output point_x, output point_y, input ready);
	modport sink (input valid, input point_x, input point_y, output ready);
endinterface

interface rtd_moved_if
	import rtd_pkg::*;
();
	logic                         valid;
	logic                         ready;
	logic signed [CoordWidth-1:0] moved_x;
	logic signed [CoordWidth-1:0] moved_y;
	logic                         clipped;

	modport source (output valid, output moved_x, output moved_y, output clipped, input ready);
	modport sink (input valid, input moved_x, input moved_y, input clipped, output ready);
endinterface

>>> rtl/rtd_regs.sv
// apb register file: angle, offsets and rotation direction
module rtd_regs
	import rtd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [AddrWidth-1:0] paddr,
	input  logic [DataWidth-1:0] pwdata,
	output logic [DataWidth-1:0] prdata,
	output logic                 pready,
	output trig_req_t            req,
	output xform_cfg_t           cfg
);

	logic signed [AngleWidth-1:0] angle_q;
	logic signed [CoordWidth-1:0] offset_x_q;
	logic signed [CoordWidth-1:0] offset_y_q;
	logic                         clockwise_q;
	logic                         wr;
	reg_idx_t                     idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q     <= '0;
			offset_x_q  <= '0;
			offset_y_q  <= '0;
			clockwise_q <= 1'b0;
		end else if (wr) begin
			unique case (idx)
				RegAngle:     angle_q     <= pwdata[AngleWidth-1:0];
				RegOffsetX:   offset_x_q  <= pwdata[CoordWidth-1:0];
				RegOffsetY:   offset_y_q  <= pwdata[CoordWidth-1:0];
				RegClockwise: clockwise_q <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			RegAngle:     prdata = DataWidth'(angle_q);
			RegOffsetX:   prdata = DataWidth'(offset_x_q);
			RegOffsetY:   prdata = DataWidth'(offset_y_q);
			RegClockwise: prdata = DataWidth'(clockwise_q);
		endcase
	end

	// the cordic loads straight from the write data
	assign req.start     = wr && (idx == RegAngle);
	assign req.angle     = pwdata[AngleWidth-1:0];
	assign cfg.offset_x  = offset_x_q;
	assign cfg.offset_y  = offset_y_q;
	assign cfg.clockwise = clockwise_q;

endmodule

>>> rtl/rtd_cordic.sv
// iterative cordic: sine and cosine of the angle, one step per cycle
module rtd_cordic
	import rtd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  trig_req_t req,
	output trig_t     trig
);

	localparam logic signed [CordicWidth-1:0] RoundK =
		CordicWidth'(1) << (CordicFrac - TrigFrac - 1);
	localparam logic signed [CordicWidth-1:0] TrigMax = CordicWidth'((1 << (TrigWidth-1)) - 1);
	localparam logic signed [CordicWidth-1:0] TrigMin = -TrigMax - CordicWidth'(1);

	logic signed [CordicWidth-1:0] x_q, y_q;
	logic signed [ZWidth-1:0]      z_q;
	logic [StepWidth-1:0]          step_q;
	logic                          neg_q;
	logic                          busy_q;
	logic signed [TrigWidth-1:0]   cos_q, sin_q;

	logic signed [AngleWidth:0]    a_ext;
	logic signed [ZWidth-1:0]      z_fold;
	logic                          neg_fold;
	logic signed [CordicWidth-1:0] dx, dy;
	logic signed [ZWidth-1:0]      at_z;
	logic signed [CordicWidth-1:0] xr, yr, xn, yn;

	function automatic logic signed [TrigWidth-1:0] sat_trig(
		input logic signed [CordicWidth-1:0] v
	);
		logic signed [CordicWidth-1:0] r;
		if (v > TrigMax)
			r = TrigMax;
		else if (v < TrigMin)
			r = TrigMin;
		else
			r = v;
		return r[TrigWidth-1:0];
	endfunction

	// fold into [-pi/2, pi/2], results negated afterwards when folded
	always_comb begin
		a_ext    = (AngleWidth+1)'(req.angle);
		neg_fold = 1'b0;
		z_fold   = ZWidth'(a_ext);
		if (a_ext > (AngleWidth+1)'(QuarterTurn)) begin
			z_fold   = ZWidth'(a_ext) - ZWidth'(HalfTurn);
			neg_fold = 1'b1;
		end else if (a_ext < -(AngleWidth+1)'(QuarterTurn)) begin
			z_fold   = ZWidth'(a_ext) + ZWidth'(HalfTurn);
			neg_fold = 1'b1;
		end
	end

	assign dx   = y_q >>> step_q;
	assign dy   = x_q >>> step_q;
	assign at_z = ZWidth'(atan_units(5'(step_q)));

	assign xr = (x_q + RoundK) >>> (CordicFrac - TrigFrac);
	assign yr = (y_q + RoundK) >>> (CordicFrac - TrigFrac);
	assign xn = neg_q ? -xr : xr;
	assign yn = neg_q ? -yr : yr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			neg_q  <= 1'b0;
			x_q    <= '0;
			y_q    <= '0;
			z_q    <= '0;
			cos_q  <= TrigWidth'(TrigOne);
			sin_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			step_q <= '0;
			neg_q  <= neg_fold;
			x_q    <= CordicWidth'(CordicGain);
			y_q    <= '0;
			z_q    <= z_fold;
		end else if (busy_q) begin
			if (step_q != StepWidth'(CordicSteps)) begin
				step_q <= step_q + StepWidth'(1);
				if (!z_q[ZWidth-1]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - at_z;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + at_z;
				end
			end else begin
				// last cycle: round to q1.16 and store
				cos_q  <= sat_trig(xn);
				sin_q  <= sat_trig(yn);
				busy_q <= 1'b0;
			end
		end
	end

	assign trig.busy   = busy_q;
	assign trig.cosine = cos_q;
	assign trig.sine   = sin_q;

endmodule

>>> rtl/rtd_pipe.sv
// four stage point pipeline: products, rounded sums, offset and saturation
module rtd_pipe
	import rtd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  xform_cfg_t        cfg,
	input  trig_t             trig,
	rtd_point_if.sink         points,
	rtd_moved_if.source       moved
);

	localparam logic signed [SumWidth-1:0] RoundHalf = SumWidth'(1) << (TrigFrac - 1);
	localparam logic signed [OffWidth-1:0] CoordMax =
		OffWidth'((64'sd1 <<< (CoordWidth-1)) - 64'sd1);
	localparam logic signed [OffWidth-1:0] CoordMin = -CoordMax - OffWidth'(1);

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	logic signed [CoordWidth-1:0] px_s1, py_s1;
	logic signed [ProdWidth-1:0]  pcx_s2, psy_s2, pcy_s2, psx_s2;
	logic signed [RndWidth-1:0]   rx_s3, ry_s3;
	logic signed [CoordWidth-1:0] mx_s4, my_s4;
	logic                         clip_s4;

	logic signed [ProdWidth-1:0]  pcx, psy, pcy, psx;
	logic signed [SumWidth-1:0]   sx, sy, tx, ty;
	logic signed [OffWidth-1:0]   ox, oy;
	logic                         clip_x, clip_y;
	logic signed [CoordWidth-1:0] satx, saty;

	// a stage moves when it is empty or the next one moves
	assign adv4 = !v_s4 || moved.ready;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign points.ready = adv1 && !trig.busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= points.valid && points.ready;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	assign pcx = px_s1 * trig.cosine;
	assign psy = py_s1 * trig.sine;
	assign pcy = py_s1 * trig.cosine;
	assign psx = px_s1 * trig.sine;

	always_comb begin
		if (cfg.clockwise) begin
			sx = pcx_s2 + psy_s2;
			sy = pcy_s2 - psx_s2;
		end else begin
			sx = pcx_s2 - psy_s2;
			sy = pcy_s2 + psx_s2;
		end
		tx = sx + RoundHalf;
		ty = sy + RoundHalf;
	end

	function automatic logic signed [CoordWidth-1:0] sat_coord(
		input  logic signed [OffWidth-1:0] v,
		output logic                       clip
	);
		logic signed [OffWidth-1:0] r;
		clip = 1'b1;
		if (v > CoordMax)
			r = CoordMax;
		else if (v < CoordMin)
			r = CoordMin;
		else begin
			r    = v;
			clip = 1'b0;
		end
		return r[CoordWidth-1:0];
	endfunction

	always_comb begin
		ox   = OffWidth'(rx_s3) + OffWidth'(cfg.offset_x);
		oy   = OffWidth'(ry_s3) + OffWidth'(cfg.offset_y);
		satx = sat_coord(ox, clip_x);
		saty = sat_coord(oy, clip_y);
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			px_s1 <= points.point_x;
			py_s1 <= points.point_y;
		end
		if (adv2) begin
			pcx_s2 <= pcx;
			psy_s2 <= psy;
			pcy_s2 <= pcy;
			psx_s2 <= psx;
		end
		if (adv3) begin
			// floor of (sum + half) / 2^16
			rx_s3 <= tx[SumWidth-1:TrigFrac];
			ry_s3 <= ty[SumWidth-1:TrigFrac];
		end
		if (adv4) begin
			mx_s4   <= satx;
			my_s4   <= saty;
			clip_s4 <= clip_x || clip_y;
		end
	end

	assign moved.valid   = v_s4;
	assign moved.moved_x = mx_s4;
	assign moved.moved_y = my_s4;
	assign moved.clipped = clip_s4;

endmodule

>>> rtl/rigid_transform_2d_points.sv
// top level: rotates each point by the set angle and adds the set offset
// One point is accepted per cycle unless the receiver holds up the pipeline or the cordic
// runs; it passes through a four stage pipeline (input register, four 32x18 products,
// rounded sums, offset add with saturation into the output register). Writing the rotation
// angle starts an iterative cordic that runs CordicSteps steps plus a rounding step; while
// it runs no point is accepted, and the old sine and cosine stay in use until it ends.
// Offsets and direction take effect at once. Coordinates are signed Q24.8, trig values
// Q1.16; each result is rounded to nearest with ties up, saturated and flagged if clipped.
module rigid_transform_2d_points
	import rtd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [AddrWidth-1:0] paddr,
	input  logic [DataWidth-1:0] pwdata,
	output logic [DataWidth-1:0] prdata,
	output logic                 pready,
	rtd_point_if.sink            points,
	rtd_moved_if.source          moved
);

	trig_req_t  req;
	trig_t      trig;
	xform_cfg_t cfg;

	rtd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req),
		.cfg     (cfg)
	);

	rtd_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.trig   (trig)
	);

	rtd_pipe u_pipe (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.trig   (trig),
		.points (points),
		.moved  (moved)
	);

	// no point enters while sine and cosine are being recomputed
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		trig.busy |-> !(points.valid && points.ready))
		else $error("point accepted during cordic run");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> trig.busy)
		else $error("angle write did not start cordic");

	// trig values change only at the end of a cordic run
	a_trig_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!trig.busy && !$past(trig.busy)) |-> ($stable(trig.cosine) && $stable(trig.sine)))
		else $error("trig values changed outside a cordic run");

endmodule

>>> tb/sv/rigid_transform_2d_points_test.sv
// self-checking testbench of the 2d rigid transform block: apb setup, point stream, word checks
`timescale 1ns / 1ps

module rigid_transform_2d_points_test;
	import rtd_pkg::*;

	localparam int StallLimit = 4000;
	localparam int PausePoint = 24;
	localparam int HoldCycles = 400;
	localparam int ReportMax  = 10;
	localparam logic [CoordWidth-1:0] CoordMax = {1'b0, {(CoordWidth-1){1'b1}}};
	localparam logic [CoordWidth-1:0] CoordMin = {1'b1, {(CoordWidth-1){1'b0}}};
	localparam int ArcUnits [CordicSteps] = '{32768, 19344, 10221, 5188, 2604, 1303, 652,
		326, 163, 81, 41, 20, 10, 5, 3, 1};

	typedef struct {
		logic signed [CoordWidth-1:0] x;
		logic signed [CoordWidth-1:0] y;
		logic                         clip;
	} moved_word_t;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [AddrWidth-1:0] paddr;
	logic [DataWidth-1:0] pwdata;
	logic [DataWidth-1:0] prdata;
	logic                 pready;

	rtd_point_if points ();
	rtd_moved_if moved ();

	rigid_transform_2d_points uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.points  (points.sink),
		.moved   (moved.source)
	);

	// predicted transform state
	logic signed [TrigWidth-1:0] cos_q;
	logic signed [TrigWidth-1:0] sin_q;
	longint                      off_x;
	longint                      off_y;
	bit                          turn_cw;

	moved_word_t moved_expect [$];
	int          fault_count;
	bit          sender_idle;
	bit          sink_idle;
	bit          hold_request;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint saturate(input longint v, input int w, inout bit clip);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			clip = 1'b1;
			return hi;
		end
		if (v < lo) begin
			clip = 1'b1;
			return lo;
		end
		return v;
	endfunction

	// fold into [-pi/2, pi/2], rotate the gain vector, round to q1.16
	function automatic void load_angle(input logic [DataWidth-1:0] raw);
		longint z;
		longint cx;
		longint cy;
		longint dx;
		longint dy;
		bit     flip;
		bit     unused_clip;
		z = longint'($signed(raw[AngleWidth-1:0]));
		cx = CordicGain;
		cy = 0;
		flip = 1'b0;
		unused_clip = 1'b0;
		if (z > QuarterTurn) begin
			z -= HalfTurn;
			flip = 1'b1;
		end else if (z < -QuarterTurn) begin
			z += HalfTurn;
			flip = 1'b1;
		end
		for (int i = 0; i < CordicSteps; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (z >= 0) begin
				cx -= dx;
				cy += dy;
				z -= ArcUnits[i];
			end else begin
				cx += dx;
				cy -= dy;
				z += ArcUnits[i];
			end
		end
		cx = (cx + (longint'(1) <<< (CordicFrac - TrigFrac - 1))) >>> (CordicFrac - TrigFrac);
		cy = (cy + (longint'(1) <<< (CordicFrac - TrigFrac - 1))) >>> (CordicFrac - TrigFrac);
		if (flip) begin
			cx = -cx;
			cy = -cy;
		end
		cx = saturate(cx, TrigWidth, unused_clip);
		cy = saturate(cy, TrigWidth, unused_clip);
		cos_q = cx[TrigWidth-1:0];
		sin_q = cy[TrigWidth-1:0];
	endfunction

	function automatic moved_word_t transform_point(input logic signed [CoordWidth-1:0] px_in,
			input logic signed [CoordWidth-1:0] py_in);
		longint      px;
		longint      py;
		longint      c;
		longint      s;
		longint      rx;
		longint      ry;
		bit          clip;
		moved_word_t w;
		px = px_in;
		py = py_in;
		c = cos_q;
		s = sin_q;
		clip = 1'b0;
		if (turn_cw) begin
			rx = px * c + py * s;
			ry = py * c - px * s;
		end else begin
			rx = px * c - py * s;
			ry = py * c + px * s;
		end
		// round half up back to the coordinate format
		rx = (rx + (longint'(1) <<< (TrigFrac - 1))) >>> TrigFrac;
		ry = (ry + (longint'(1) <<< (TrigFrac - 1))) >>> TrigFrac;
		rx = saturate(rx + off_x, CoordWidth, clip);
		ry = saturate(ry + off_y, CoordWidth, clip);
		w.x = rx[CoordWidth-1:0];
		w.y = ry[CoordWidth-1:0];
		w.clip = clip;
		return w;
	endfunction

	function automatic logic [CoordWidth-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return CoordMax;
			1: return CoordMin;
			2, 3, 4: return CoordWidth'($signed($urandom_range(0, 8191)) - 4096);
			default: return CoordWidth'($urandom);
		endcase
	endfunction

	task automatic report_fault(input string msg);
		if (fault_count < ReportMax)
			$display("%s", msg);
		fault_count++;
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [DataWidth-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			RegAngle: load_angle(value);
			RegOffsetX: off_x = longint'($signed(value[CoordWidth-1:0]));
			RegOffsetY: off_y = longint'($signed(value[CoordWidth-1:0]));
			RegClockwise: turn_cw = value[0];
		endcase
	endtask

	// wait for the pipeline and any cordic run to finish, then load a new transform
	task automatic set_transform(input logic [AngleWidth-1:0] angle, input logic [CoordWidth-1:0] ox,
			input logic [CoordWidth-1:0] oy, input bit cw);
		logic [DataWidth-1:0] raw;
		// let the last accepted point reach the queue first
		@(posedge clk);
		while (moved_expect.size() != 0) @(posedge clk);
		repeat (PausePoint) @(posedge clk);
		write_reg(RegOffsetX, ox);
		write_reg(RegOffsetY, oy);
		// upper bits are don't-care
		raw = $urandom;
		raw[0] = cw;
		write_reg(RegClockwise, raw);
		raw = $urandom;
		raw[AngleWidth-1:0] = angle;
		write_reg(RegAngle, raw);
	endtask

	task automatic random_transform();
		logic [AngleWidth-1:0] angle;
		logic [CoordWidth-1:0] ox;
		logic [CoordWidth-1:0] oy;
		case ($urandom_range(0, 5))
			0: angle = AngleWidth'(-HalfTurn);
			1: angle = AngleWidth'(HalfTurn - 1);
			default: angle = AngleWidth'($urandom);
		endcase
		case ($urandom_range(0, 5))
			0: ox = CoordMax;
			1: ox = CoordMin;
			2, 3: ox = CoordWidth'($signed($urandom_range(0, 65535)) - 32768);
			default: ox = CoordWidth'($urandom);
		endcase
		case ($urandom_range(0, 5))
			0: oy = CoordMax;
			1: oy = CoordMin;
			2, 3: oy = CoordWidth'($signed($urandom_range(0, 65535)) - 32768);
			default: oy = CoordWidth'($urandom);
		endcase
		set_transform(angle, ox, oy, $urandom_range(0, 1));
	endtask

	// valid stays high when the next point follows at once
	task automatic send_point(input logic [CoordWidth-1:0] x, input logic [CoordWidth-1:0] y);
		if (sender_idle && $urandom_range(0, 3) == 0) begin
			points.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		points.valid <= 1'b1;
		points.point_x <= x;
		points.point_y <= y;
		do @(posedge clk); while (!points.ready);
	endtask

	task automatic send_random_points(input int count);
		for (int i = 0; i < count; i++)
			send_point(rand_coord(), rand_coord());
		points.valid <= 1'b0;
	endtask

	task automatic test_reset_trig();
		send_point(CoordMax, CoordMax);
		send_point(CoordMin, CoordMin);
		send_point(CoordMin, CoordMax);
		send_point('0, '0);
		send_point('1, 32'sd1);
		points.valid <= 1'b0;
	endtask

	task automatic test_saturation();
		set_transform('0, CoordMax, CoordMax, 1'b0);
		send_point(CoordMax, CoordMax);
		send_point(CoordMin, CoordMin);
		send_point('0, CoordMax);
		points.valid <= 1'b0;
		set_transform('0, CoordMin, CoordMin, 1'b1);
		send_point(CoordMin, CoordMin);
		send_point(CoordMax, CoordMax);
		send_point(CoordMin, '0);
		points.valid <= 1'b0;
	endtask

	// folding at both quarter turns and both ends of the range, plus angle zero via cordic
	task automatic test_angle_folding();
		int angles [7] = '{-HalfTurn, -QuarterTurn - 1, -QuarterTurn, QuarterTurn,
			QuarterTurn + 1, HalfTurn - 1, 0};
		for (int i = 0; i < 7; i++) begin
			set_transform(AngleWidth'(angles[i]), CoordWidth'($urandom_range(0, 255)),
				CoordWidth'(-$signed($urandom_range(0, 255))), i[0]);
			send_point(CoordWidth'(32'sd256), CoordWidth'(-32'sd384));
			send_point(rand_coord(), rand_coord());
			points.valid <= 1'b0;
		end
	endtask

	task automatic test_random_transforms();
		for (int phase = 0; phase < 10; phase++) begin
			random_transform();
			send_random_points(100);
		end
	endtask

	task automatic test_output_stall();
		random_transform();
		sender_idle = 1'b0;
		hold_request = 1'b1;
		send_random_points(60);
		sender_idle = 1'b1;
	endtask

	task automatic test_steady_stream();
		sender_idle = 1'b0;
		sink_idle = 1'b0;
		random_transform();
		send_random_points(200);
	endtask

	// receiver side: random stalls and one long hold-off on request
	initial begin
		int hold_left;
		int stall_left;
		hold_left = 0;
		stall_left = 0;
		moved.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HoldCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				moved.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				moved.ready <= 1'b0;
			end else if (sink_idle && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 16) - 1;
				moved.ready <= 1'b0;
			end else begin
				moved.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && points.valid && points.ready)
			moved_expect.insert(moved_expect.size(),
				transform_point(points.point_x, points.point_y));
	end

	always @(posedge clk) begin
		moved_word_t want;
		if (arst_n && moved.valid && moved.ready) begin
			if (moved_expect.size() == 0) begin
				report_fault($sformatf("unexpected word x=%0d y=%0d clip=%0b",
					moved.moved_x, moved.moved_y, moved.clipped));
			end else begin
				want = moved_expect.pop_front();
				if (moved.moved_x !== want.x || moved.moved_y !== want.y
						|| moved.clipped !== want.clip)
					report_fault($sformatf(
						"mismatch: expected x=%0d y=%0d clip=%0b, got x=%0d y=%0d clip=%0b",
						want.x, want.y, want.clip, moved.moved_x, moved.moved_y, moved.clipped));
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < StallLimit) begin
			@(posedge clk);
			if ((points.valid && points.ready) || (moved.valid && moved.ready) || (psel && penable))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("rigid_transform_2d_points_test: errors");
		$finish;
	end

	initial begin
		fault_count = 0;
		sender_idle = 1'b1;
		sink_idle = 1'b1;
		hold_request = 1'b0;
		cos_q = TrigWidth'(TrigOne);
		sin_q = '0;
		off_x = 0;
		off_y = 0;
		turn_cw = 1'b0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		points.valid <= 1'b0;
		points.point_x <= '0;
		points.point_y <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_trig();
		test_saturation();
		test_angle_folding();
		test_random_transforms();
		test_output_stall();
		test_steady_stream();

		@(posedge clk);
		while (moved_expect.size() != 0) @(posedge clk);
		repeat (PausePoint) @(posedge clk);
		if (fault_count == 0 && moved_expect.size() == 0)
			$display("rigid_transform_2d_points_test: clean");
		else
			$display("rigid_transform_2d_points_test: errors");
		$finish;
	end

endmodule

>>> rigid_transform_2d_points.f
rtl/rtd_pkg.sv
rtl/rtd_if.sv
rtl/rtd_regs.sv
rtl/rtd_cordic.sv
rtl/rtd_pipe.sv
rtl/rigid_transform_2d_points.sv
tb/sv/rigid_transform_2d_points_test.sv
